// ===== hdl/lkx_pkg.sv =====
// Package for the LCG keystream XOR cipher.
// Holds the credential layout, the LCG constants and the register index codes.
// No dependencies; imported by every module of the block.
package lkx_pkg;

	// Credential storage: four 64-bit words per credential, bytes little-endian
	localparam int WORDS_PER_CRED = 4;
	localparam int CRED_WORD_W    = 64;
	localparam int CRED_SLOTS     = WORDS_PER_CRED * CRED_WORD_W / 8;

	// Number of credential bytes taken into the checksum (at most CRED_SLOTS)
	localparam int CRED_BYTES     = 32;

	// Key and LCG constants
	localparam int          KEY_W   = 31;
	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;
	localparam logic [31:0] LCG_MOD = 32'h7FFF_FFFF;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = CRED_WORD_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_USER_WORD0 = 4'd0,
		CFG_USER_WORD1 = 4'd1,
		CFG_USER_WORD2 = 4'd2,
		CFG_USER_WORD3 = 4'd3,
		CFG_PASS_WORD0 = 4'd4,
		CFG_PASS_WORD1 = 4'd5,
		CFG_PASS_WORD2 = 4'd6,
		CFG_PASS_WORD3 = 4'd7
	} cfg_index_t;

	typedef logic [WORDS_PER_CRED-1:0][CRED_WORD_W-1:0] cred_words_t;

	// Pipeline control handed from the top level to the key stage
	typedef struct packed {
		logic advance;  // pipeline moves this cycle
		logic valid;    // stage 1 holds an item
	} stage_ctl_t;

endpackage

// ===== hdl/lcg_keystream_xor_cipher.sv =====
// Top level of the LCG keystream XOR byte cipher.
// Depends on lkx_pkg, lkx_checksum and lkx_keystream.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one byte item: first_byte,
//   sequence_req and data_in. Raise first_byte on the first byte of a message
//   to reseed the key from sequence_req and the two credential checksums.
//   Output channel (out_valid/out_stall) carries data_out, the byte XOR the
//   low byte of the advanced key. Running the same stream through twice with
//   the same credentials and sequence numbers decrypts it.
//   Credentials are loaded through wr_en/wr_index/wr_data while the block is
//   idle; indexes 0-3 are username words, 4-7 password words, others ignored.
//   Checksums are registered behind the credential word registers.
// Pipeline:
//   An accepted item passes the input register, then the result register that
//   drives the output; one item is accepted every cycle unless stalled. The key
//   loop (multiply, add, fold) is combinational around the key register and
//   sets the clock. Checksums come from a registered adder tree.
// Reset and stall:
//   Reset clears the key, the credential words and both valid flags.
//   While the output is stalled with a result pending the whole pipeline
//   holds and in_stall is raised; no item is dropped or repeated.
module lcg_keystream_xor_cipher
	import lkx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  first_byte,
	input  logic [7:0]            sequence_req,
	input  logic [7:0]            data_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            data_out
);

	cred_words_t user_words_q;
	cred_words_t pass_words_q;
	logic [7:0]  user_sum;
	logic [7:0]  pass_sum;

	logic        valid_s1;
	logic        first_s1;
	logic [7:0]  seq_s1;
	logic [7:0]  data_s1;
	logic        out_valid_q;
	logic        advance;
	stage_ctl_t  ctl;

	// Credential words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_words_q <= '0;
			pass_words_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_USER_WORD0: user_words_q[0] <= wr_data;
				CFG_USER_WORD1: user_words_q[1] <= wr_data;
				CFG_USER_WORD2: user_words_q[2] <= wr_data;
				CFG_USER_WORD3: user_words_q[3] <= wr_data;
				CFG_PASS_WORD0: pass_words_q[0] <= wr_data;
				CFG_PASS_WORD1: pass_words_q[1] <= wr_data;
				CFG_PASS_WORD2: pass_words_q[2] <= wr_data;
				CFG_PASS_WORD3: pass_words_q[3] <= wr_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	lkx_checksum u_user_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.words    (user_words_q),
		.checksum (user_sum)
	);

	lkx_checksum u_pass_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.words    (pass_words_q),
		.checksum (pass_sum)
	);

	// Advance the pipeline unless a result waits on a stalled receiver
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			out_valid_q <= valid_s1;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			first_s1 <= first_byte;
			seq_s1   <= sequence_req;
			data_s1  <= data_in;
		end
	end

	assign ctl.advance = advance;
	assign ctl.valid   = valid_s1;

	lkx_keystream u_keystream (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.first_s1 (first_s1),
		.seq_s1   (seq_s1),
		.data_s1  (data_s1),
		.user_sum (user_sum),
		.pass_sum (pass_sum),
		.data_out (data_out)
	);

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/lkx_checksum.sv =====
// Registered credential checksum: inverted 8-bit sum of bytes up to the first zero.
// Depends on lkx_pkg. Prefix mask per byte, then a five-level adder tree.
module lkx_checksum
	import lkx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cred_words_t words,
	output logic [7:0]  checksum
);

	logic [CRED_SLOTS-1:0][7:0] bytes;
	logic [CRED_SLOTS-1:0]      nonzero;
	logic [CRED_SLOTS-1:0]      keep;
	logic [31:0][7:0]           lvl0;
	logic [15:0][7:0]           lvl1;
	logic [7:0][7:0]            lvl2;
	logic [3:0][7:0]            lvl3;
	logic [1:0][7:0]            lvl4;
	logic [7:0]                 sum;
	logic [7:0]                 checksum_q;

	assign bytes = words;

	always_comb begin
		for (int i = 0; i < CRED_SLOTS; i++) begin
			nonzero[i] = (bytes[i] != 8'd0);
		end
		// keep byte i only when every earlier byte is nonzero
		for (int i = 0; i < CRED_SLOTS; i++) begin
			keep[i] = (i < CRED_BYTES) &&
				(&(nonzero | ~((CRED_SLOTS'(1) << i) - CRED_SLOTS'(1))));
		end
		for (int i = 0; i < 32; i++) begin
			lvl0[i] = keep[i] ? bytes[i] : 8'd0;
		end
		for (int i = 0; i < 16; i++) lvl1[i] = lvl0[2*i] + lvl0[2*i+1];
		for (int i = 0; i < 8; i++)  lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
		for (int i = 0; i < 4; i++)  lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
		for (int i = 0; i < 2; i++)  lvl4[i] = lvl3[2*i] + lvl3[2*i+1];
		sum = lvl4[0] + lvl4[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_q <= 8'hFF;
		end else begin
			checksum_q <= ~sum;
		end
	end

	assign checksum = checksum_q;

endmodule

// ===== hdl/lkx_keystream.sv =====
// Key stage: reseed, LCG advance with Mersenne fold, XOR of the data byte.
// Depends on lkx_pkg. Holds the key register and the result byte register.
module lkx_keystream
	import lkx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  stage_ctl_t ctl,
	input  logic       first_s1,
	input  logic [7:0] seq_s1,
	input  logic [7:0] data_s1,
	input  logic [7:0] user_sum,
	input  logic [7:0] pass_sum,
	output logic [7:0] data_out
);

	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] key_in;
	logic [KEY_W-1:0] key_next;
	logic [31:0]      prod;
	logic [31:0]      lcg_t;
	logic [31:0]      fold;
	logic [31:0]      reduced;
	logic [7:0]       data_out_q;

	always_comb begin
		key_in  = first_s1 ? {7'd0, seq_s1, user_sum, pass_sum} : key_q;
		prod    = {1'b0, key_in} * LCG_MUL;
		lcg_t   = prod + LCG_ADD;
		// fold bit 31 back in: 2^31 is 1 modulo 2^31-1
		fold    = {1'b0, lcg_t[30:0]} + {31'd0, lcg_t[31]};
		reduced = (fold >= LCG_MOD) ? fold - LCG_MOD : fold;
		key_next = reduced[KEY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (ctl.advance && ctl.valid) begin
			key_q <= key_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && ctl.valid) begin
			data_out_q <= data_s1 ^ key_next[7:0];
		end
	end

	assign data_out = data_out_q;

endmodule
